// ----- rtl/vcu_pkg.sv -----
// Package for the vector clock unit: sizes, operation codes and the
// command struct shared by the controller and the datapath. No dependencies.
package vcu_pkg;

    // Number of thread slots and width of one logical clock counter.
    localparam int NUM_SLOTS  = 16;
    localparam int CLOCK_BITS = 32;

    // Fixed field widths of the transaction payloads.
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 32;

    // Bits needed to address one slot of the register file.
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef logic [CLOCK_BITS-1:0] t_clock;
    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_READ    = 2'd1,
        KIND_MERGE   = 2'd2,
        KIND_COMPARE = 2'd3
    } t_kind;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic load;    // accept the input transaction and update the result register
    } t_dp_cmd;

endpackage

// ----- rtl/vcu_in_if.sv -----
// Input channel of the vector clock unit: valid/ready handshake and the item payload.
// Depends on vcu_pkg for field widths.
interface vcu_in_if;
    logic                       valid;
    logic                       ready;
    logic [vcu_pkg::KIND_W-1:0]  kind;
    logic [vcu_pkg::SLOT_W-1:0]  thread_slot;
    logic [vcu_pkg::VALUE_W-1:0] other_value;
    logic                       last_element;

    modport source (output valid, kind, thread_slot, other_value, last_element,
                    input ready);
    modport sink   (input valid, kind, thread_slot, other_value, last_element,
                    output ready);
endinterface

// ----- rtl/vcu_out_if.sv -----
// Output channel of the vector clock unit: valid/ready handshake and the result payload.
// Depends on vcu_pkg for field widths.
interface vcu_out_if;
    logic                       valid;
    logic                       ready;
    logic [vcu_pkg::VALUE_W-1:0] slot_value;
    logic                       compare_done;
    logic                       happens_before;
    logic                       happens_after;
    logic                       saturated;

    modport source (output valid, slot_value, compare_done, happens_before,
                    happens_after, saturated, input ready);
    modport sink   (input valid, slot_value, compare_done, happens_before,
                    happens_after, saturated, output ready);
endinterface

// ----- rtl/vector_clock_unit_core.sv -----
// Top level of the vector clock unit: joins the controller and the datapath to the
// input and output channel interfaces. Depends on vcu_pkg, vcu_in_if, vcu_out_if.
//
// The unit keeps one logical clock counter per thread slot, all zero after reset,
// and handles one transaction per cycle: the accepted item reads, updates and
// writes back its slot in the cycle it is accepted, and the result lands in an
// output register that is presented on the next cycle. The slot counters live
// in a flip-flop register file, so the read-modify-write there sets the rate;
// nothing is stalled except by a full output register whose result is not
// taken. Tick adds one (saturating, with the saturated
// flag), read returns the slot, merge keeps the larger of slot and other_value, and
// compare folds one element of another clock into running flags and reports
// happens-before and happens-after on the element marked last. A compare run must
// send every slot once; slots the other clock lacks go in as zero. Tick, read and
// merge items inside a run leave the run's flags alone.
module vector_clock_unit_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vcu_in_if.sink     i_item,
    vcu_out_if.source  o_result
);

    vcu_pkg::t_dp_cmd w_cmd;
    logic             w_in_ready;
    logic             w_out_valid;

    // Handshake control: own the output register occupancy and the load strobe.
    vcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // Slot counters, compare flags and the result register.
    vcu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_kind           (i_item.kind),
        .i_thread_slot    (i_item.thread_slot),
        .i_other_value    (i_item.other_value),
        .i_last_element   (i_item.last_element),
        .o_slot_value     (o_result.slot_value),
        .o_compare_done   (o_result.compare_done),
        .o_happens_before (o_result.happens_before),
        .o_happens_after  (o_result.happens_after),
        .o_saturated      (o_result.saturated)
    );

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;

endmodule

// ----- rtl/vcu_ctrl.sv -----
// Controller of the vector clock unit: tracks whether the result register holds
// an untaken transaction and issues the load command. Depends on vcu_pkg.
module vcu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output vcu_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_load;

    // Take a new transaction when the result register is free or drains this cycle.
    assign o_in_ready = (r_state == ST_EMPTY) || i_out_ready;
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (w_load) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (i_out_ready && !w_load) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
        n_out_valid = (n_state == ST_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_load;

    // A load never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("load while result register still held");

    // A load always leaves a result to present next cycle.
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("result register empty after load");

    // The registered valid mirrors the state.
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid == (r_state == ST_FULL))
        else $error("output valid out of step with state");

endmodule

// ----- rtl/vcu_dp.sv -----
// Datapath of the vector clock unit: slot counter register file, running compare
// flags and the result register. Depends on vcu_pkg.
module vcu_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vcu_pkg::t_dp_cmd            i_cmd,
    input  logic [vcu_pkg::KIND_W-1:0]  i_kind,
    input  logic [vcu_pkg::SLOT_W-1:0]  i_thread_slot,
    input  logic [vcu_pkg::VALUE_W-1:0] i_other_value,
    input  logic                        i_last_element,
    output logic [vcu_pkg::VALUE_W-1:0] o_slot_value,
    output logic                        o_compare_done,
    output logic                        o_happens_before,
    output logic                        o_happens_after,
    output logic                        o_saturated
);

    vcu_pkg::t_clock r_clocks [vcu_pkg::NUM_SLOTS];

    logic r_own_never_greater;
    logic r_own_somewhere_less;
    logic r_other_never_greater;
    logic r_other_somewhere_less;

    logic n_own_never_greater;
    logic n_own_somewhere_less;
    logic n_other_never_greater;
    logic n_other_somewhere_less;

    logic [vcu_pkg::VALUE_W-1:0] r_slot_value;
    logic                        r_compare_done;
    logic                        r_happens_before;
    logic                        r_happens_after;
    logic                        r_saturated;

    vcu_pkg::t_kind    w_kind;
    vcu_pkg::t_slot_idx w_idx;
    logic              w_in_range;
    vcu_pkg::t_clock   w_other;
    vcu_pkg::t_clock   w_own;
    vcu_pkg::t_clock   w_new;
    logic              w_wr;
    logic              w_own_gt;
    logic              w_own_lt;
    logic              w_done;
    logic              w_hb;
    logic              w_ha;
    logic              w_sat;
    logic              w_fold_ng;
    logic              w_fold_sl;
    logic              w_fold_ong;
    logic              w_fold_osl;

    assign w_kind     = vcu_pkg::t_kind'(i_kind);
    assign w_idx      = vcu_pkg::SLOT_IDX_W'(i_thread_slot);
    assign w_in_range = int'(i_thread_slot) < vcu_pkg::NUM_SLOTS;
    assign w_other    = vcu_pkg::CLOCK_BITS'(i_other_value);
    assign w_own      = w_in_range ? r_clocks[w_idx] : '0;
    assign w_own_gt   = w_own > w_other;
    assign w_own_lt   = w_own < w_other;

    // Running flags with this element folded in.
    assign w_fold_ng  = r_own_never_greater && !w_own_gt;
    assign w_fold_sl  = r_own_somewhere_less || w_own_lt;
    assign w_fold_ong = r_other_never_greater && !w_own_lt;
    assign w_fold_osl = r_other_somewhere_less || w_own_gt;

    always_comb begin
        w_new                  = w_own;
        w_wr                   = 1'b0;
        w_done                 = 1'b0;
        w_hb                   = 1'b0;
        w_ha                   = 1'b0;
        w_sat                  = 1'b0;
        n_own_never_greater    = r_own_never_greater;
        n_own_somewhere_less   = r_own_somewhere_less;
        n_other_never_greater  = r_other_never_greater;
        n_other_somewhere_less = r_other_somewhere_less;
        unique case (w_kind)
            vcu_pkg::KIND_TICK: begin
                if (w_in_range) begin
                    if (&w_own) begin
                        w_sat = 1'b1;
                    end else begin
                        w_new = w_own + 1'b1;
                        w_wr  = 1'b1;
                    end
                end
            end
            vcu_pkg::KIND_READ: begin
            end
            vcu_pkg::KIND_MERGE: begin
                if (w_in_range && (w_other > w_own)) begin
                    w_new = w_other;
                    w_wr  = 1'b1;
                end
            end
            vcu_pkg::KIND_COMPARE: begin
                if (i_last_element) begin
                    w_done                 = 1'b1;
                    w_hb                   = w_fold_ng && w_fold_sl;
                    w_ha                   = w_fold_ong && w_fold_osl;
                    n_own_never_greater    = 1'b1;
                    n_own_somewhere_less   = 1'b0;
                    n_other_never_greater  = 1'b1;
                    n_other_somewhere_less = 1'b0;
                end else begin
                    n_own_never_greater    = w_fold_ng;
                    n_own_somewhere_less   = w_fold_sl;
                    n_other_never_greater  = w_fold_ong;
                    n_other_somewhere_less = w_fold_osl;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vcu_pkg::NUM_SLOTS; i++) begin
                r_clocks[i] <= '0;
            end
            r_own_never_greater    <= 1'b1;
            r_own_somewhere_less   <= 1'b0;
            r_other_never_greater  <= 1'b1;
            r_other_somewhere_less <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_wr) begin
                r_clocks[w_idx] <= w_new;
            end
            r_own_never_greater    <= n_own_never_greater;
            r_own_somewhere_less   <= n_own_somewhere_less;
            r_other_never_greater  <= n_other_never_greater;
            r_other_somewhere_less <= n_other_somewhere_less;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot_value     <= vcu_pkg::VALUE_W'(w_new);
            r_compare_done   <= w_done;
            r_happens_before <= w_hb;
            r_happens_after  <= w_ha;
            r_saturated      <= w_sat;
        end
    end

    assign o_slot_value     = r_slot_value;
    assign o_compare_done   = r_compare_done;
    assign o_happens_before = r_happens_before;
    assign o_happens_after  = r_happens_after;
    assign o_saturated      = r_saturated;

    // The end of a compare run leaves the running flags at their cleared values.
    a_flags_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (w_kind == vcu_pkg::KIND_COMPARE) && i_last_element) |=>
        (r_own_never_greater && !r_own_somewhere_less &&
         r_other_never_greater && !r_other_somewhere_less))
        else $error("compare flags not cleared after last element");

    // A run cannot report both orders at once.
    a_order_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !(r_happens_before && r_happens_after))
        else $error("happens-before and happens-after both set");

    // Non-compare items leave the running flags untouched.
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (w_kind != vcu_pkg::KIND_COMPARE)) |=>
        ($stable(r_own_never_greater) && $stable(r_own_somewhere_less) &&
         $stable(r_other_never_greater) && $stable(r_other_somewhere_less)))
        else $error("compare flags moved on a non-compare item");

endmodule
